// File: rtl/core/wlb_pkg.sv
// ----------------------------------------------------------------------------
// Weighted link balancer package
// Shared widths, register indexes and the controller state type.
// ----------------------------------------------------------------------------
package wlb_pkg;

    // Field and register widths.
    localparam int LEN_W       = 16;
    localparam int LINK_CNT_W  = 3;
    localparam int WEIGHT_W    = 8;
    localparam int INDEX_W     = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;
    localparam int NUM_WEIGHTS = 4;

    // Load lanes are rotated one digit per cycle during the subtract pass.
    localparam int LOAD_W    = 32;
    localparam int DIGIT_W   = 4;
    localparam int SUB_STEPS = LOAD_W / DIGIT_W;

    // Dividend is the length plus a stored remainder; one quotient bit per cycle.
    localparam int DIV_W     = LEN_W + 1;
    localparam int DIV_STEPS = DIV_W;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_LINK_COUNT   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_ZERO  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_ONE   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_TWO   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_THREE = 3'd4;

    // Controller states, one-hot.
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SEARCH = 5'b00010,
        ST_PREP   = 5'b00100,
        ST_RUN    = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

endpackage

// File: rtl/core/weighted_link_balancer.sv
// ----------------------------------------------------------------------------
// Weighted link balancer
// Picks the output link with the least weighted load for each packet.
// ----------------------------------------------------------------------------
// Usage:
// A packet length beat enters on in_valid/in_stall and one link_index beat
// leaves on out_valid/out_stall for every packet. The configuration port
// (cfg_write, cfg_index, cfg_data) sets the link count and the four weights
// and must only be written while no packet is in flight.
// A packet first scans the active links for the smallest load, one link per
// cycle, then a 17-step restoring divider works out (length + remainder) /
// weight one quotient bit per cycle. While it runs, the other loads are
// reduced by the minimum in a digit-serial pass, four bits per cycle.
// One packet occupies the block through the search, the preparation, the
// division and the hand-over; in_stall holds off the next one until then;
// the serial divider is the longest part. The result appears one cycle
// after the division ends and a new packet may be taken in the next cycle.
// A result held by out_stall stays in the output register; the next packet
// is still accepted and only waits at its end for the register to drain.
// Reset clears all loads and remainders, sets the link count to one and the
// weight of link 0 to one, with all other weights zero.
// ----------------------------------------------------------------------------
module weighted_link_balancer
    import wlb_pkg::*;
#(
    parameter int MAX_LINKS = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [LEN_W-1:0]       packet_length,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [INDEX_W-1:0]     link_index
);

    localparam int SEL_W = $clog2(MAX_LINKS);
    localparam int CAP   = (MAX_LINKS < NUM_WEIGHTS) ? MAX_LINKS : NUM_WEIGHTS;
    localparam logic [SEL_W-1:0] LAST_LINK = SEL_W'(MAX_LINKS - 1);

    // Configuration registers.
    logic [LINK_CNT_W-1:0] link_count_reg, link_count_next;
    logic [WEIGHT_W-1:0]   weight_reg  [NUM_WEIGHTS];
    logic [WEIGHT_W-1:0]   weight_next [NUM_WEIGHTS];

    // Per-link state.
    logic [LOAD_W-1:0]     load_reg  [MAX_LINKS];
    logic [LOAD_W-1:0]     load_next [MAX_LINKS];
    logic [WEIGHT_W-1:0]   rem_reg   [MAX_LINKS];
    logic [WEIGHT_W-1:0]   rem_next  [MAX_LINKS];
    logic [MAX_LINKS-1:0]  borrow_reg, borrow_next;

    // Controller and datapath registers.
    state_t                state_reg, state_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [LOAD_W-1:0]     min_reg, min_next;
    logic [SEL_W-1:0]      best_reg, best_next;
    logic [SEL_W-1:0]      cursor_reg, cursor_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [DIV_W-1:0]      div_reg, div_next;
    logic [WEIGHT_W-1:0]   part_reg, part_next;
    logic [WEIGHT_W-1:0]   divisor_reg, divisor_next;
    logic                  out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]    index_reg, index_next;

    // Derived link information.
    logic [WEIGHT_W-1:0]   weight_vec [MAX_LINKS];
    logic [3:0]            limit;
    logic [MAX_LINKS-1:0]  active;

    // Division step signals.
    logic [WEIGHT_W:0]     trial;
    logic                  q_bit;
    logic [WEIGHT_W-1:0]   part_step;

    // Digit subtract signals.
    logic [DIGIT_W:0]      diff;

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign link_index = index_reg;

    // Weights per link; links beyond the weight registers have none.
    always_comb
    begin
        for (int i = 0; i < MAX_LINKS; i++)
        begin
            if (i < NUM_WEIGHTS)
                weight_vec[i] = weight_reg[i];
            else
                weight_vec[i] = '0;
        end
    end

    // Active links: link 0 and the following ones up to the clamped count,
    // ending at the first zero weight.
    always_comb
    begin
        if (link_count_reg == '0)
            limit = 4'd1;
        else if (4'(link_count_reg) > 4'(CAP))
            limit = 4'(CAP);
        else
            limit = 4'(link_count_reg);
        active[0] = 1'b1;
        for (int i = 1; i < MAX_LINKS; i++)
            active[i] = active[i-1] && (4'(i) < limit) && (weight_vec[i] != '0);
    end

    // One restoring division step.
    always_comb
    begin
        trial     = {part_reg, div_reg[DIV_W-1]};
        q_bit     = (trial >= {1'b0, divisor_reg});
        part_step = q_bit ? WEIGHT_W'(trial - {1'b0, divisor_reg}) : trial[WEIGHT_W-1:0];
    end

    // Next-state logic.
    always_comb
    begin
        link_count_next = link_count_reg;
        weight_next     = weight_reg;
        load_next       = load_reg;
        rem_next        = rem_reg;
        borrow_next     = borrow_reg;
        state_next      = state_reg;
        len_next        = len_reg;
        min_next        = min_reg;
        best_next       = best_reg;
        cursor_next     = cursor_reg;
        step_next       = step_reg;
        div_next        = div_reg;
        part_next       = part_reg;
        divisor_next    = divisor_reg;
        out_valid_next  = out_valid_reg;
        index_next      = index_reg;
        diff            = '0;

        // Configuration writes.
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_LINK_COUNT:   link_count_next = cfg_data[LINK_CNT_W-1:0];
                REG_WEIGHT_ZERO:  weight_next[0]  = cfg_data;
                REG_WEIGHT_ONE:   weight_next[1]  = cfg_data;
                REG_WEIGHT_TWO:   weight_next[2]  = cfg_data;
                REG_WEIGHT_THREE: weight_next[3]  = cfg_data;
                default: ;
            endcase
        end

        // Output register drains when the receiver takes the beat.
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    len_next    = packet_length;
                    min_next    = load_reg[0];
                    best_next   = '0;
                    cursor_next = SEL_W'(1);
                    state_next  = ST_SEARCH;
                end
            end

            // Minimum search, one link per cycle; ties keep the lower index.
            ST_SEARCH:
            begin
                if (active[cursor_reg] && (load_reg[cursor_reg] < min_reg))
                begin
                    min_next  = load_reg[cursor_reg];
                    best_next = cursor_reg;
                end
                if (!active[cursor_reg] || (cursor_reg == LAST_LINK))
                    state_next = ST_PREP;
                else
                    cursor_next = cursor_reg + SEL_W'(1);
            end

            // Load the dividend and divisor, clear the subtract borrows.
            ST_PREP:
            begin
                div_next     = {1'b0, len_reg} + DIV_W'(rem_reg[best_reg]);
                part_next    = '0;
                divisor_next = (weight_vec[best_reg] == '0) ? WEIGHT_W'(1)
                                                            : weight_vec[best_reg];
                borrow_next  = '0;
                step_next    = '0;
                state_next   = ST_RUN;
            end

            // Serial division alongside the digit-serial subtract pass.
            ST_RUN:
            begin
                if (step_reg < STEP_W'(SUB_STEPS))
                begin
                    for (int i = 0; i < MAX_LINKS; i++)
                    begin
                        if (active[i])
                        begin
                            diff = {1'b0, load_reg[i][DIGIT_W-1:0]}
                                 - {1'b0, min_reg[DIGIT_W-1:0]}
                                 - (DIGIT_W+1)'(borrow_reg[i]);
                            borrow_next[i] = diff[DIGIT_W];
                            load_next[i]   = {diff[DIGIT_W-1:0], load_reg[i][LOAD_W-1:DIGIT_W]};
                        end
                    end
                    min_next = {min_reg[DIGIT_W-1:0], min_reg[LOAD_W-1:DIGIT_W]};
                end
                div_next  = {div_reg[DIV_W-2:0], q_bit};
                part_next = part_step;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    // The chosen link held the minimum, so its load is now
                    // just the quotient.
                    load_next[best_reg] = LOAD_W'({div_reg[DIV_W-2:0], q_bit});
                    rem_next[best_reg]  = part_step;
                    state_next          = ST_DONE;
                end
            end

            // Hand the result over once the output register is free.
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    index_next     = INDEX_W'(best_reg);
                    state_next     = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_count_reg <= LINK_CNT_W'(1);
            for (int i = 0; i < NUM_WEIGHTS; i++)
                weight_reg[i] <= (i == 0) ? WEIGHT_W'(1) : '0;
            for (int i = 0; i < MAX_LINKS; i++)
            begin
                load_reg[i] <= '0;
                rem_reg[i]  <= '0;
            end
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            link_count_reg <= link_count_next;
            weight_reg     <= weight_next;
            load_reg       <= load_next;
            rem_reg        <= rem_next;
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        borrow_reg  <= borrow_next;
        len_reg     <= len_next;
        min_reg     <= min_next;
        best_reg    <= best_next;
        cursor_reg  <= cursor_next;
        step_reg    <= step_next;
        div_reg     <= div_next;
        part_reg    <= part_next;
        divisor_reg <= divisor_next;
        index_reg   <= index_next;
    end

endmodule

// File: dv/weighted_link_balancer_tb.sv
// ----------------------------------------------------------------------------
// Weighted link balancer testbench
// Drives packet lengths through the balancer under several link settings and
// checks every chosen link index against an in-bench least-load predictor.
// A directed part covers the edge cases and is followed by random phases.
// Both handshakes idle and stall at random, with some phases left clean.
// ----------------------------------------------------------------------------
module weighted_link_balancer_tb;
    import wlb_pkg::*;

    localparam int MAX_LINKS   = 4;
    localparam int PACKET_GOAL = 1650;
    localparam int CYCLE_LIMIT = 1500000;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [LEN_W-1:0]       packet_length;
    logic                   out_valid;
    logic                   out_stall;
    logic [INDEX_W-1:0]     link_index;

    // Idling controls, switched per phase.
    bit idle_on;
    bit stall_on;
    int stall_left;
    int cycle_count;
    int packets_sent;
    int settings_used;

    // Least-load predictor and store of expected link choices.
    class link_scoreboard;
        logic [LINK_CNT_W-1:0] link_count;
        logic [WEIGHT_W-1:0]   weight [NUM_WEIGHTS];
        logic [LOAD_W-1:0]     load [MAX_LINKS];
        logic [WEIGHT_W-1:0]   remainder [MAX_LINKS];
        logic [INDEX_W-1:0]    expected_links [$];
        int                    mismatches;
        int                    checked;

        function void clear_state();
            int i;
            link_count = LINK_CNT_W'(1);
            for (i = 0; i < NUM_WEIGHTS; i++)
                weight[i] = '0;
            weight[0] = WEIGHT_W'(1);
            for (i = 0; i < MAX_LINKS; i++)
            begin
                load[i]      = '0;
                remainder[i] = '0;
            end
            expected_links.delete();
            mismatches = 0;
            checked    = 0;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] idx,
                                     logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_LINK_COUNT:   link_count = data[LINK_CNT_W-1:0];
                REG_WEIGHT_ZERO:  weight[0]  = data;
                REG_WEIGHT_ONE:   weight[1]  = data;
                REG_WEIGHT_TWO:   weight[2]  = data;
                REG_WEIGHT_THREE: weight[3]  = data;
                default: ;
            endcase
        endfunction

        // Pick the least-loaded active link and charge the packet to it.
        function logic [INDEX_W-1:0] choose_link(logic [LEN_W-1:0] len);
            int                  limit;
            int                  active;
            int                  best;
            int                  i;
            logic [LOAD_W-1:0]   lowest;
            logic [LEN_W:0]      total;
            logic [WEIGHT_W-1:0] divisor;
            limit = link_count;
            if (limit < 1)
                limit = 1;
            if (limit > MAX_LINKS)
                limit = MAX_LINKS;
            if (limit > NUM_WEIGHTS)
                limit = NUM_WEIGHTS;
            active = 1;
            while (active < limit && weight[active] != 0)
                active++;
            best   = 0;
            lowest = load[0];
            for (i = 1; i < active; i++)
            begin
                if (load[i] < lowest)
                begin
                    lowest = load[i];
                    best   = i;
                end
            end
            for (i = 0; i < active; i++)
                load[i] = load[i] - lowest;
            divisor         = (weight[best] == 0) ? WEIGHT_W'(1) : weight[best];
            total           = len + remainder[best];
            load[best]      = load[best] + LOAD_W'(total / divisor);
            remainder[best] = WEIGHT_W'(total % divisor);
            return INDEX_W'(best);
        endfunction

        function void note_packet(logic [LEN_W-1:0] len);
            expected_links.push_back(choose_link(len));
        endfunction

        function int pending();
            return expected_links.size();
        endfunction

        task report_mismatch(string msg);
            $display("ERROR at cycle %0d: %s", cycle_count, msg);
            mismatches++;
        endtask

        task check_link(logic [INDEX_W-1:0] got);
            logic [INDEX_W-1:0] want;
            checked++;
            if (expected_links.size() == 0)
            begin
                report_mismatch($sformatf("link %0d leaves with no packet waiting", got));
            end
            else
            begin
                want = expected_links.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("link_index %0d, expected %0d", got, want));
            end
        endtask
    endclass

    link_scoreboard sb = new;

    weighted_link_balancer #(
        .MAX_LINKS(MAX_LINKS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .packet_length(packet_length),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .link_index   (link_index)
    );

    // Clock.
    always #5 clk = ~clk;

    // Watch the ports: register writes, accepted lengths and returned links.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write)
                sb.write_register(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                sb.note_packet(packet_length);
            if (out_valid && !out_stall)
                sb.check_link(link_index);
        end
    end

    // Receiver stall pattern: runs of stall and release, mostly short.
    always @(posedge clk)
    begin
        int r;
        if (!stall_on)
        begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
            begin
                out_stall  <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end
            else if (r < 88)
            begin
                out_stall  <= 1'b1;
                stall_left = $urandom_range(0, 3);
            end
            else
            begin
                out_stall  <= 1'b1;
                stall_left = $urandom_range(10, 40);
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("weighted_link_balancer_tb: done, errors");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [LEN_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        case ($urandom_range(0, 4))
            0: if (r < 10) return '0;
            1: if (r < 10) return '1;
            2: if (r < 10) return LEN_W'(1);
            default: ;
        endcase
        if (r < 35)
            return LEN_W'($urandom_range(0, 300));
        if (r < 65)
            return LEN_W'($urandom_range(1200, 1500));
        return LEN_W'($urandom);
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight(bit may_be_zero);
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return may_be_zero ? WEIGHT_W'(0) : WEIGHT_W'($urandom_range(1, 255));
        if (r < 35)
            return WEIGHT_W'(1);
        if (r < 50)
            return '1;
        return WEIGHT_W'($urandom_range(1, 255));
    endfunction

    // One beat on the packet channel, after a random gap.
    task automatic send_packet(input logic [LEN_W-1:0] len);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        packet_length <= len;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        packets_sent++;
    endtask

    // Stop sending and wait until every expected link has come back.
    // The first edge lets the monitor note the last accepted beat.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Write all registers; the unused bits of the count carry random data.
    task automatic configure(input logic [LINK_CNT_W-1:0] count,
                             input logic [WEIGHT_W-1:0] w0,
                             input logic [WEIGHT_W-1:0] w1,
                             input logic [WEIGHT_W-1:0] w2,
                             input logic [WEIGHT_W-1:0] w3);
        logic [CFG_DATA_W-1:0] count_word;
        count_word                   = CFG_DATA_W'($urandom);
        count_word[LINK_CNT_W-1:0]   = count;
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_INDEX_W'(REG_WEIGHT_THREE + $urandom_range(1, 3)),
                      CFG_DATA_W'($urandom));
        write_reg(REG_LINK_COUNT, count_word);
        write_reg(REG_WEIGHT_ZERO, w0);
        write_reg(REG_WEIGHT_ONE, w1);
        write_reg(REG_WEIGHT_TWO, w2);
        write_reg(REG_WEIGHT_THREE, w3);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    task automatic random_setting();
        int                    r;
        logic [LINK_CNT_W-1:0] count;
        r = $urandom_range(0, 99);
        if (r < 70)
            count = LINK_CNT_W'($urandom_range(1, 4));
        else if (r < 85)
            count = '0;
        else
            count = LINK_CNT_W'($urandom_range(5, 7));
        configure(count,
                  ($urandom_range(0, 9) == 0) ? WEIGHT_W'(0) : pick_weight(1'b0),
                  pick_weight(1'b1), pick_weight(1'b1), pick_weight(1'b1));
    endtask

    // Main sequence.
    initial
    begin
        int phase;
        int burst;
        int i;
        rst_n         <= 1'b0;
        cfg_write     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        packet_length <= '0;
        idle_on       = 1'b1;
        stall_on      = 1'b1;
        sb.clear_state();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: a single link of weight one.
        send_packet(16'd1);
        send_packet('1);
        send_packet('0);
        drain();

        // All four links at the largest weight; equal loads go to link 0.
        configure(3'd4, 8'd255, 8'd255, 8'd255, 8'd255);
        send_packet('1);
        send_packet('0);
        send_packet(16'd1);
        send_packet(16'hAAAA);
        send_packet(16'd300);
        drain();

        // Link 0 with zero weight divides by one.
        configure(3'd2, 8'd0, 8'd7, 8'd0, 8'd0);
        send_packet(16'd10);
        send_packet(16'd10);
        send_packet('0);
        drain();

        // A link count of zero leaves link 0 alone.
        configure(3'd0, 8'd5, 8'd5, 8'd5, 8'd5);
        send_packet(16'd9);
        send_packet(16'd9);
        drain();

        // A count above the number of links is clamped.
        configure(3'd7, 8'd3, 8'd1, 8'd2, 8'd4);
        for (i = 0; i < 4; i++)
            send_packet(16'd100);
        drain();

        // A zero weight ends the active list early.
        configure(3'd4, 8'd200, 8'd0, 8'd9, 8'd9);
        send_packet(16'd50);
        send_packet(16'd50);
        drain();

        // Leave large remainders, then lower the weights beneath them.
        configure(3'd4, 8'd200, 8'd200, 8'd200, 8'd200);
        for (i = 0; i < 4; i++)
            send_packet(16'd199);
        drain();
        configure(3'd4, 8'd3, 8'd3, 8'd3, 8'd3);
        send_packet('0);
        send_packet(16'd1);
        drain();

        // Random phases, the first two at the weight extremes.
        phase = 0;
        while (packets_sent < PACKET_GOAL)
        begin
            if (phase == 0)
                configure(3'd4, 8'd255, 8'd255, 8'd255, 8'd255);
            else if (phase == 1)
                configure(3'd4, 8'd1, 8'd1, 8'd1, 8'd1);
            else
                random_setting();
            idle_on  = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
            burst    = $urandom_range(60, 200);
            for (i = 0; i < burst && packets_sent < PACKET_GOAL; i++)
                send_packet(pick_length());
            drain();
            phase++;
        end

        repeat (30) @(posedge clk);
        $display("Balanced %0d packets under %0d link settings; %0d link choices checked.",
                 packets_sent, settings_used, sb.checked);
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("weighted_link_balancer_tb: done, clean");
        end
        else
        begin
            $display("weighted_link_balancer_tb: done, errors");
        end
        $finish;
    end

endmodule
